@@ src/tcp_signature_feature_scorer_assert.svh @@
// Assertion macros for the TCP signature feature scorer.
// Used by the top level; define NO_ASSERTIONS to compile them out.
`ifndef TCP_SIGNATURE_FEATURE_SCORER_ASSERT_SVH
`define TCP_SIGNATURE_FEATURE_SCORER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define TSFS_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsfs assertion failed");
// Next-cycle implication.
`define TSFS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsfs assertion failed");
`else
`define TSFS_ASSERT_IMP(name, clk, rst, ante, cons)
`define TSFS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ src/tsfs_pkg.sv @@
// Shared types and constants of the TCP signature feature scorer.
// No dependencies; used by every module of the block.
`default_nettype none
package tsfs_pkg;

  localparam int OPTION_SLOTS_DEF = 21;
  localparam int OPT_LIST_W       = 63;
  localparam int OPT_CODE_W       = 3;
  localparam int KEY_CODES        = 4;
  localparam int SLOT_POS_W       = 5;

  localparam logic [15:0] FEATURE_PROB_RESET = 16'd6554;
  localparam logic [15:0] RARE_PROB_RESET    = 16'd655;

  // Register map, selected by paddr[2].
  localparam logic REG_FEATURE = 1'b0;
  localparam logic REG_RARE    = 1'b1;

  // Options ordering result codes.
  localparam logic [1:0] OPT_VIOLATED = 2'd0;
  localparam logic [1:0] OPT_COMPAT   = 2'd1;
  localparam logic [1:0] OPT_EXACT    = 2'd2;

  typedef struct packed {
    logic win;
    logic ttl;
    logic df;
    logic mss;
    logic rst_on;
    logic rst_eq;
  } tsfs_match_t;

  typedef struct packed {
    logic                                   eq;
    logic [KEY_CODES-1:0]                   found;
    logic [KEY_CODES-1:0][SLOT_POS_W-1:0]   fpos;
    logic [KEY_CODES-1:0][KEY_CODES-1:0]    prec;
  } tsfs_opt_prep_t;

endpackage
`default_nettype wire

@@ src/tsfs_order_prep.sv @@
// First half of the options ordering check: list equality, first position of
// each key option in the signature list, and which key codes precede which.
// Depends on tsfs_pkg.
`default_nettype none
module tsfs_order_prep import tsfs_pkg::*; #(
  parameter int OPTION_SLOTS = OPTION_SLOTS_DEF
) (
  input  wire logic [OPT_LIST_W-1:0] tgt_options,
  input  wire logic [OPT_LIST_W-1:0] sig_options,
  output tsfs_opt_prep_t             prep
);

  localparam int USED_W = OPT_CODE_W * OPTION_SLOTS;

  logic [KEY_CODES-1:0][OPTION_SLOTS-1:0] tgt_hit;

  always_comb begin
    for (int b = 0; b < KEY_CODES; b++) begin
      for (int k = 0; k < OPTION_SLOTS; k++) begin
        tgt_hit[b][k] = (tgt_options[OPT_CODE_W*k +: OPT_CODE_W] == OPT_CODE_W'(b + 1));
      end
    end
  end

  always_comb begin
    prep.eq = (tgt_options[USED_W-1:0] == sig_options[USED_W-1:0]);

    // Lowest matching slot wins, so scan from the top down.
    for (int b = 0; b < KEY_CODES; b++) begin
      prep.found[b] = 1'b0;
      prep.fpos[b]  = '0;
      for (int j = OPTION_SLOTS - 1; j >= 0; j--) begin
        if (sig_options[OPT_CODE_W*j +: OPT_CODE_W] == OPT_CODE_W'(b + 1)) begin
          prep.found[b] = 1'b1;
          prep.fpos[b]  = SLOT_POS_W'(j);
        end
      end
    end

    // prec[a][b] is set when some target slot holding code b has an earlier
    // target slot holding code a.
    for (int a = 0; a < KEY_CODES; a++) begin
      for (int b = 0; b < KEY_CODES; b++) begin
        prep.prec[a][b] = 1'b0;
        for (int k = 1; k < OPTION_SLOTS; k++) begin
          for (int i = 0; i < k; i++) begin
            prep.prec[a][b] = prep.prec[a][b] | (tgt_hit[b][k] & tgt_hit[a][i]);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/tsfs_order_resolve.sv @@
// Second half of the options ordering check: turns the prepared positions
// into the options code. Depends on tsfs_pkg.
`default_nettype none
module tsfs_order_resolve import tsfs_pkg::*; (
  input  tsfs_opt_prep_t   prep,
  output logic [1:0]       code
);

  logic violated;

  // An inversion between any two found key codes, in target order, is a
  // violation; a nondecreasing sequence has none.
  always_comb begin
    violated = 1'b0;
    for (int a = 0; a < KEY_CODES; a++) begin
      for (int b = 0; b < KEY_CODES; b++) begin
        violated = violated | (prep.prec[a][b] & prep.found[a] & prep.found[b] &
                               (prep.fpos[a] > prep.fpos[b]));
      end
    end
  end

  always_comb begin
    priority if (prep.eq) begin
      code = OPT_EXACT;
    end else if (violated) begin
      code = OPT_VIOLATED;
    end else begin
      code = OPT_COMPAT;
    end
  end

endmodule
`default_nettype wire

@@ src/tsfs_score_stage.sv @@
// One pipeline stage of the score chain: multiplies the Q0.32 score by a Q1.16
// factor and truncates; apply low passes it through. Depends on tsfs_pkg.
`default_nettype none
module tsfs_score_stage import tsfs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] score_in,
  input  wire logic        apply,
  input  wire logic        match,
  input  wire logic [15:0] prob,
  output logic      [31:0] score_out
);

  logic [16:0] factor;
  logic [48:0] product;

  // A match scales by one minus the probability, a mismatch by the probability.
  assign factor  = match ? (17'h10000 - {1'b0, prob}) : {1'b0, prob};
  assign product = {17'd0, score_in} * {32'd0, factor};

  always_ff @(posedge clk) begin
    if (en) begin
      score_out <= apply ? product[47:16] : score_in;
    end
  end

endmodule
`default_nettype wire

@@ src/tcp_signature_feature_scorer.sv @@
// TCP signature feature scorer, top level.
// Depends on tsfs_pkg, tsfs_order_prep, tsfs_order_resolve, tsfs_score_stage
// and the assertion header.
//
// One input transaction carries a prior score and a target and database
// signature; one output transaction returns the scaled score and the options
// ordering code. Both channels use valid/ready.
// The block is a seven-register pipeline: an input register, then six
// stages that each apply one feature factor with one 32x17 multiplier
// (window, TTL, DF, options, MSS, RST). The options ordering check runs in
// the first two stages alongside the score chain.
// A new transaction is accepted every cycle while the output side keeps up.
// When the receiver stalls, the pipeline keeps flowing until each stage
// holds a transaction and then drops in_ready; empty stages fill first.
// Reset clears all valid bits and loads the probability registers with
// about 0.1 and 0.01. The APB port writes and reads the two probability
// registers at byte addresses 0 and 4; write them only while idle.
`default_nettype none
`include "tcp_signature_feature_scorer_assert.svh"
module tcp_signature_feature_scorer import tsfs_pkg::*; #(
  parameter int OPTION_SLOTS = OPTION_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [31:0]           prior_score,
  input  wire logic [40:0]           tgt_header,
  input  wire logic [OPT_LIST_W-1:0] tgt_options,
  input  wire logic [18:0]           tgt_reset_info,
  input  wire logic [40:0]           sig_header,
  input  wire logic [OPT_LIST_W-1:0] sig_options,
  input  wire logic [18:0]           sig_reset_info,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [31:0]                score,
  output logic [1:0]                 options_code,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int STAGES = 7;

  // Configuration registers.
  logic [15:0] feature_prob;
  logic [15:0] rare_prob;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = {16'd0, (paddr[2] == REG_RARE) ? rare_prob : feature_prob};

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_prob <= FEATURE_PROB_RESET;
      rare_prob    <= RARE_PROB_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_FEATURE) begin
        feature_prob <= pwdata[15:0];
      end else begin
        rare_prob <= pwdata[15:0];
      end
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor moves.
  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Stage 0: input register.
  logic [31:0]           score0;
  logic [40:0]           th0;
  logic [40:0]           sh0;
  logic [OPT_LIST_W-1:0] to0;
  logic [OPT_LIST_W-1:0] so0;
  logic [18:0]           tr0;
  logic [18:0]           sr0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      score0 <= prior_score;
      th0    <= tgt_header;
      sh0    <= sig_header;
      to0    <= tgt_options;
      so0    <= sig_options;
      tr0    <= tgt_reset_info;
      sr0    <= sig_reset_info;
    end
  end

  tsfs_match_t    mt0;
  tsfs_opt_prep_t prep0;

  always_comb begin
    mt0.win    = (th0[40:25] == sh0[40:25]);
    mt0.ttl    = (th0[24:17] == sh0[24:17]);
    mt0.df     = (th0[16] == sh0[16]);
    mt0.mss    = (th0[15:0] == sh0[15:0]);
    mt0.rst_on = tr0[18];
    mt0.rst_eq = (tr0 == sr0);
  end

  tsfs_order_prep #(
    .OPTION_SLOTS(OPTION_SLOTS)
  ) u_order_prep (
    .tgt_options(to0),
    .sig_options(so0),
    .prep       (prep0)
  );

  // Stages 1-5 carry the match flags and 1-6 the options check with the score.
  tsfs_match_t    mt1, mt2, mt3, mt4, mt5;
  tsfs_opt_prep_t prep1;
  logic [1:0]     code1, code2, code3, code4, code5, code6;
  logic [31:0]    score1, score2, score3, score4, score5, score6;

  tsfs_order_resolve u_order_resolve (
    .prep(prep1),
    .code(code1)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mt1   <= mt0;
      prep1 <= prep0;
    end
    if (en[2]) begin
      mt2   <= mt1;
      code2 <= code1;
    end
    if (en[3]) begin
      mt3   <= mt2;
      code3 <= code2;
    end
    if (en[4]) begin
      mt4   <= mt3;
      code4 <= code3;
    end
    if (en[5]) begin
      mt5   <= mt4;
      code5 <= code4;
    end
    if (en[6]) begin
      code6 <= code5;
    end
  end

  tsfs_score_stage u_stage_win (
    .clk(clk), .en(en[1]), .score_in(score0), .apply(1'b1),
    .match(mt0.win), .prob(feature_prob), .score_out(score1)
  );

  tsfs_score_stage u_stage_ttl (
    .clk(clk), .en(en[2]), .score_in(score1), .apply(1'b1),
    .match(mt1.ttl), .prob(feature_prob), .score_out(score2)
  );

  tsfs_score_stage u_stage_df (
    .clk(clk), .en(en[3]), .score_in(score2), .apply(1'b1),
    .match(mt2.df), .prob(feature_prob), .score_out(score3)
  );

  tsfs_score_stage u_stage_opt (
    .clk(clk), .en(en[4]), .score_in(score3), .apply(1'b1),
    .match(code3 == OPT_EXACT), .prob(rare_prob), .score_out(score4)
  );

  tsfs_score_stage u_stage_mss (
    .clk(clk), .en(en[5]), .score_in(score4), .apply(1'b1),
    .match(mt4.mss), .prob(feature_prob), .score_out(score5)
  );

  // The RST group only counts when the target carries an RST.
  tsfs_score_stage u_stage_rst (
    .clk(clk), .en(en[6]), .score_in(score5), .apply(mt5.rst_on),
    .match(mt5.rst_eq), .prob(rare_prob), .score_out(score6)
  );

  assign score        = score6;
  assign options_code = code6;

  `TSFS_ASSERT_IMP(a_stall_only_when_full, clk, rst, !in_ready, (&valid) && !out_ready)
  `TSFS_ASSERT_NEXT(a_stalled_stage_kept, clk, rst, valid[STAGES-2] && !en[STAGES-1], valid[STAGES-1] && valid[STAGES-2])
  `TSFS_ASSERT_NEXT(a_cfg_feature_write, clk, rst, cfg_write && pready && paddr[2] == REG_FEATURE, feature_prob == $past(pwdata[15:0]))

endmodule
`default_nettype wire
